### design/sfat_pkg.sv
// shared types, constants and helpers for the screen fade alpha timer
// no dependencies; imported by the controller, datapath and top level
package sfat_pkg;

  // default tick resolution, fraction bits of a second
  localparam int TIME_FRAC_BITS_DEF = 12;

  // field widths
  localparam int TIME_W = 32;
  localparam int SPAN_W = 20;
  localparam int PROD_W = 40;           // alpha times time magnitude
  localparam int NUM_W  = PROD_W + 12;  // product times 4096
  localparam int QUO_W  = 9;            // quotient bits kept, bit 8 flags at least 256
  localparam int ADD_W  = 40;           // operand width of the saturating add

  // request function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_LEVEL = 2'd2;

  // mode bit positions
  localparam int MODE_OUT  = 0;
  localparam int MODE_STAY = 1;
  localparam int MODE_LONG = 2;

  // span used by the dark level start, 5 s in 1/4096 s
  localparam logic [SPAN_W-1:0] DARK_SPAN = 20'd20480;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD1,
    S_LOAD2,
    S_LVL1,
    S_LVL2,
    S_QSETUP,
    S_MUL,
    S_DIVINIT,
    S_DIV,
    S_RESOLVE,
    S_FIN
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD1,
    OP_LOAD2,
    OP_LVL1,
    OP_LVL2,
    OP_QSETUP,
    OP_MUL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_RESOLVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       need_div;
    logic       div_last;
  } dp_status_t;

  // time sum clamped at the top of the 32-bit range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [ADD_W-1:0] b);
    logic [ADD_W:0] s;
    s = {{(ADD_W + 1 - TIME_W){1'b0}}, a} + {1'b0, b};
    if (s > {{(ADD_W + 1 - TIME_W){1'b0}}, {TIME_W{1'b1}}}) begin
      return {TIME_W{1'b1}};
    end
    return s[TIME_W-1:0];
  endfunction

endpackage

### design/sfat_ctrl.sv
// sequencer for the screen fade alpha timer: handshakes and datapath commands
// depends on sfat_pkg
module sfat_ctrl
  import sfat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.func)
          FUNC_LOAD:  state_nxt = S_LOAD1;
          FUNC_LEVEL: state_nxt = S_LVL1;
          default:    state_nxt = S_QSETUP;
        endcase
      end
      S_LOAD1: begin
        cmd.op    = OP_LOAD1;
        state_nxt = S_LOAD2;
      end
      S_LOAD2: begin
        cmd.op    = OP_LOAD2;
        state_nxt = S_FIN;
      end
      S_LVL1: begin
        cmd.op    = OP_LVL1;
        state_nxt = S_LVL2;
      end
      S_LVL2: begin
        cmd.op    = OP_LVL2;
        state_nxt = S_FIN;
      end
      S_QSETUP: begin
        cmd.op    = OP_QSETUP;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = status.need_div ? S_DIVINIT : S_FIN;
      end
      S_DIVINIT: begin
        cmd.op    = OP_DIVINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIVSTEP;
        if (status.div_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd.op    = OP_RESOLVE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // no request is taken while in reset
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/sfat_dp.sv
// datapath for the screen fade alpha timer: fade state, multiplier,
// radix-2 divider and output register; depends on sfat_pkg
module sfat_dp
  import sfat_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_time_now,
  input  logic [15:0] in_fade_length,
  input  logic [15:0] in_hold_length,
  input  logic [7:0]  in_color_red,
  input  logic [7:0]  in_color_green,
  input  logic [7:0]  in_color_blue,
  input  logic [7:0]  in_alpha_level,
  input  logic        in_fade_out,
  input  logic        in_stay_out,
  input  logic        in_long_scale,
  input  logic        in_start_dark,
  output logic [7:0]  out_fade_alpha,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int TICK_W = SPAN_W + TIME_FRAC_BITS;
  localparam int DEN_W  = SPAN_W + TIME_FRAC_BITS;
  localparam int DIV_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
  localparam int CNT_W  = $clog2(QUO_W);
  localparam logic [ADD_W-1:0] FIVE_T  = ADD_W'(5) << TIME_FRAC_BITS;
  localparam logic [ADD_W-1:0] TENTH_T = ADD_W'(((1 << TIME_FRAC_BITS) + 5) / 10);

  // captured request
  logic [1:0]  func_r;
  logic [31:0] now_r;
  logic [15:0] flen_r, hlen_r;
  logic [23:0] rgb_in_r;
  logic [7:0]  alev_r;
  logic        fout_r, stay_r, long_r, dark_r;

  // fade state
  logic [31:0]       end_r, end_nxt;
  logic [31:0]       hold_r, hold_nxt;
  logic [31:0]       odone_r, odone_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [7:0]        peak_r, peak_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [23:0]       color_r, color_nxt;

  // query working registers
  logic [31:0]       mag_r, mag_nxt;
  logic              need_div_r, need_div_nxt;
  logic              sub_r, sub_nxt;
  logic              ceil_r, ceil_nxt;
  logic [7:0]        alpha_r, alpha_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // output register
  logic [7:0]  oalpha_r;
  logic [23:0] ocolor_r;

  // scaled durations in ticks
  logic [SPAN_W-1:0] dur_w, hold_w;
  logic [TICK_W-1:0] dur_t, hold_t;
  logic [ADD_W-1:0]  dur_x, hold_x;

  assign dur_w  = long_r ? {flen_r, 4'b0} : {4'b0, flen_r};
  assign hold_w = long_r ? {hlen_r, 4'b0} : {4'b0, hlen_r};
  assign dur_t  = (TICK_W'(dur_w) << TIME_FRAC_BITS) >> 12;
  assign hold_t = (TICK_W'(hold_w) << TIME_FRAC_BITS) >> 12;
  assign dur_x  = ADD_W'(dur_t);
  assign hold_x = ADD_W'(hold_t);

  // divider operands
  logic [DIV_W-1:0] num_x, den_x;
  assign num_x = DIV_W'({prod_r, 12'b0});
  assign den_x = DIV_W'(span_r) << TIME_FRAC_BITS;

  // quotient resolution
  logic       x_big;
  logic [8:0] c9, a9;
  assign x_big = ovf_r | quo_r[QUO_W-1];
  assign a9    = {1'b0, peak_r};
  assign c9    = {1'b0, quo_r[7:0]} + {8'b0, ceil_r & (rem_r != '0)};

  // capture registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      func_r   <= in_func;
      now_r    <= in_time_now;
      flen_r   <= in_fade_length;
      hlen_r   <= in_hold_length;
      rgb_in_r <= {in_color_red, in_color_green, in_color_blue};
      alev_r   <= in_alpha_level;
      fout_r   <= in_fade_out;
      stay_r   <= in_stay_out;
      long_r   <= in_long_scale;
      dark_r   <= in_start_dark;
    end
  end

  // fade state and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r      <= '0;
      hold_r     <= '0;
      odone_r    <= '0;
      span_r     <= '0;
      peak_r     <= '0;
      mode_r     <= '0;
      color_r    <= '0;
      need_div_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      end_r      <= end_nxt;
      hold_r     <= hold_nxt;
      odone_r    <= odone_nxt;
      span_r     <= span_nxt;
      peak_r     <= peak_nxt;
      mode_r     <= mode_nxt;
      color_r    <= color_nxt;
      need_div_r <= need_div_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    sub_r   <= sub_nxt;
    ceil_r  <= ceil_nxt;
    alpha_r <= alpha_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    quo_r   <= quo_nxt;
    ovf_r   <= ovf_nxt;
    if (cmd.op == OP_MUL) begin
      prod_r <= PROD_W'(peak_r) * PROD_W'(mag_r);
    end
    if (cmd.out_load) begin
      oalpha_r <= alpha_r;
      ocolor_r <= color_r;
    end
  end

  // operation decode
  always_comb begin
    end_nxt      = end_r;
    hold_nxt     = hold_r;
    odone_nxt    = odone_r;
    span_nxt     = span_r;
    peak_nxt     = peak_r;
    mode_nxt     = mode_r;
    color_nxt    = color_r;
    mag_nxt      = mag_r;
    need_div_nxt = need_div_r;
    sub_nxt      = sub_r;
    ceil_nxt     = ceil_r;
    alpha_nxt    = alpha_r;
    rem_nxt      = rem_r;
    dsh_nxt      = dsh_r;
    quo_nxt      = quo_r;
    ovf_nxt      = ovf_r;
    cnt_nxt      = cnt_r;
    case (cmd.op)
      OP_CAPTURE: begin
        alpha_nxt    = '0;
        need_div_nxt = 1'b0;
      end
      // store command, first time sum
      OP_LOAD1: begin
        color_nxt = rgb_in_r;
        peak_nxt  = alev_r;
        mode_nxt  = {long_r, stay_r, fout_r};
        span_nxt  = dur_w;
        if (dur_w == '0) begin
          end_nxt  = '0;
          hold_nxt = sat_add('0, hold_x);
        end else if (fout_r) begin
          end_nxt   = sat_add(now_r, dur_x);
          odone_nxt = sat_add(now_r, dur_x);
        end else begin
          hold_nxt = sat_add(now_r, hold_x);
        end
      end
      // second time sum, chained on the first
      OP_LOAD2: begin
        if (dur_w != '0) begin
          if (mode_r[MODE_OUT]) begin
            hold_nxt = sat_add(end_r, hold_x);
          end else begin
            end_nxt = sat_add(hold_r, dur_x);
          end
        end
      end
      OP_LVL1: begin
        color_nxt = '0;
        mode_nxt  = '0;
        if (!dark_r) begin
          span_nxt = '0;
          end_nxt  = '0;
          hold_nxt = '0;
          peak_nxt = '0;
        end else begin
          hold_nxt = sat_add(now_r, FIVE_T);
          span_nxt = DARK_SPAN;
          peak_nxt = 8'd255;
        end
      end
      OP_LVL2: begin
        if (dark_r) begin
          end_nxt = sat_add(hold_r, FIVE_T);
        end
      end
      // classify the query, settle the cases that need no division
      OP_QSETUP: begin
        need_div_nxt = 1'b0;
        sub_nxt      = 1'b0;
        ceil_nxt     = 1'b0;
        if (!mode_r[MODE_STAY]) begin
          if (hold_r < now_r && end_r < now_r) begin
            alpha_nxt = '0;
          end else if (span_r == '0 || end_r < now_r) begin
            // ramp term zero or already past its end
            alpha_nxt = mode_r[MODE_OUT] ? peak_r : 8'd0;
          end else begin
            need_div_nxt = 1'b1;
            sub_nxt      = mode_r[MODE_OUT];
            mag_nxt      = end_r - now_r;
          end
        end else begin
          alpha_nxt = peak_r;
          if (mode_r[MODE_OUT] && odone_r > now_r) begin
            if (span_r != '0) begin
              need_div_nxt = 1'b1;
              sub_nxt      = 1'b1;
              ceil_nxt     = 1'b1;
              mag_nxt      = odone_r - now_r;
            end
          end else begin
            end_nxt = sat_add(now_r, TENTH_T);
          end
        end
      end
      OP_DIVINIT: begin
        rem_nxt = num_x;
        dsh_nxt = den_x << (QUO_W - 1);
        ovf_nxt = (num_x >= (den_x << QUO_W));
        quo_nxt = '0;
        cnt_nxt = CNT_W'(QUO_W - 1);
      end
      // one restoring step per cycle
      OP_DIVSTEP: begin
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      // clamp ramp term into 0..peak
      OP_RESOLVE: begin
        if (!sub_r) begin
          alpha_nxt = (x_big || quo_r[7:0] > peak_r) ? peak_r : quo_r[7:0];
        end else if (x_big || c9 > a9) begin
          alpha_nxt = '0;
        end else begin
          alpha_nxt = 8'(a9 - c9);
        end
      end
      default: ;
    endcase
  end

  assign status.func     = func_r;
  assign status.need_div = need_div_r;
  assign status.div_last = (cnt_r == '0);

  assign out_fade_alpha = oalpha_r;
  assign out_red        = ocolor_r[23:16];
  assign out_green      = ocolor_r[15:8];
  assign out_blue       = ocolor_r[7:0];

endmodule

### design/screen_fade_alpha_timer_core.sv
// top level of the screen fade alpha timer
// depends on sfat_pkg, sfat_ctrl and sfat_dp
//
// Usage: every request on the in_ channel carries the current time in ticks
// of 2^-TIME_FRAC_BITS s and a function code: load a fade command, query the
// alpha, or start a level. Each request gives exactly one result on the out_
// channel: the alpha (zero for load and level start) and the stored colour.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Load and level start use neither the multiplier nor the divider; a query
// runs an 8x32 multiply, and one that needs the ramp term then runs the
// 9-step radix-2 divider. One request is in flight at a time: no new request
// is taken until the last one has been moved into the output register.
// A finished result sits in the output register; the next request is
// accepted while it waits, and only its completion waits for the receiver to
// drop out_stall.
// Reset clears the fade state (times, span, peak alpha, mode, colour) to zero and
// empties the output register; in_stall stays high while rst_n is low.
module screen_fade_alpha_timer_core
  import sfat_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_time_now,
  input  logic [15:0] in_fade_length,
  input  logic [15:0] in_hold_length,
  input  logic [7:0]  in_color_red,
  input  logic [7:0]  in_color_green,
  input  logic [7:0]  in_color_blue,
  input  logic [7:0]  in_alpha_level,
  input  logic        in_fade_out,
  input  logic        in_stay_out,
  input  logic        in_long_scale,
  input  logic        in_start_dark,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_fade_alpha,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  sfat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // fade state and arithmetic
  sfat_dp #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_func),
    .in_time_now    (in_time_now),
    .in_fade_length (in_fade_length),
    .in_hold_length (in_hold_length),
    .in_color_red   (in_color_red),
    .in_color_green (in_color_green),
    .in_color_blue  (in_color_blue),
    .in_alpha_level (in_alpha_level),
    .in_fade_out    (in_fade_out),
    .in_stay_out    (in_stay_out),
    .in_long_scale  (in_long_scale),
    .in_start_dark  (in_start_dark),
    .out_fade_alpha (out_fade_alpha),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule
